// File: rtl/i2cms_pkg.sv
package i2cms_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_SEGMENT = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_STATUS  = 2'd2;
  localparam logic [1:0] CMD_END     = 2'd3;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RX_ACK  = 3'd3;
  localparam logic [2:0] ACT_RX_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;

  localparam logic [1:0] WANTS_BUS     = 2'd0;
  localparam logic [1:0] WANTS_SEGMENT = 2'd1;
  localparam logic [1:0] WANTS_WRITE   = 2'd2;

  localparam logic [7:0] STATUS_MASK      = 8'hF8;
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_REP_START     = 8'h10;
  localparam logic [7:0] ST_MTX_ADR_ACK   = 8'h18;
  localparam logic [7:0] ST_MTX_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MRX_ADR_ACK   = 8'h40;
  localparam logic [7:0] ST_MRX_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MRX_DATA_NACK = 8'h58;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] address_rw;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] action_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [1:0] wants;
    logic       done_res;
    logic       failed;
    logic [7:0] fail_status;
  } out_item_t;

  typedef struct packed {
    logic is_segment;
    logic is_write;
    logic is_status;
    logic is_end;
  } cmd_class_t;

  typedef struct packed {
    logic start_ok;
    logic addr_ok;
    logic wdata_ok;
    logic rx_ack;
    logic rx_nack;
  } status_class_t;

  typedef struct packed {
    cmd_class_t    cmd;
    status_class_t st;
    logic [7:0]    address_rw;
    logic [7:0]    byte_count;
    logic [7:0]    write_byte;
    logic [7:0]    bus_status;
    logic [7:0]    received_byte;
  } cls_item_t;

endpackage

// File: rtl/i2cms_front.sv
module i2cms_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cms_pkg::in_item_t   in_data,
  input  logic                  queue_full,
  output logic                  push,
  output i2cms_pkg::cls_item_t  cls
);

  logic [7:0] code;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;
  assign code     = in_data.bus_status & i2cms_pkg::STATUS_MASK;

  always_comb begin
    cls.cmd.is_segment = (in_data.command == i2cms_pkg::CMD_SEGMENT);
    cls.cmd.is_write   = (in_data.command == i2cms_pkg::CMD_WRITE);
    cls.cmd.is_status  = (in_data.command == i2cms_pkg::CMD_STATUS);
    cls.cmd.is_end     = (in_data.command == i2cms_pkg::CMD_END);
    cls.st.start_ok    = code inside {i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START};
    cls.st.addr_ok     = code inside {i2cms_pkg::ST_MTX_ADR_ACK, i2cms_pkg::ST_MRX_ADR_ACK};
    cls.st.wdata_ok    = (code == i2cms_pkg::ST_MTX_DATA_ACK);
    cls.st.rx_ack      = (code == i2cms_pkg::ST_MRX_DATA_ACK);
    cls.st.rx_nack     = (code == i2cms_pkg::ST_MRX_DATA_NACK);
    cls.address_rw     = in_data.address_rw;
    cls.byte_count     = in_data.byte_count;
    cls.write_byte     = in_data.write_byte;
    cls.bus_status     = in_data.bus_status;
    cls.received_byte  = in_data.received_byte;
  end

endmodule

// File: rtl/i2cms_queue.sv
module i2cms_queue #(
  parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  i2cms_pkg::cls_item_t  push_data,
  input  logic                  pop,
  output i2cms_pkg::cls_item_t  head,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cms_pkg::cls_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/i2cms_back.sv
module i2cms_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  queue_empty,
  input  i2cms_pkg::cls_item_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cms_pkg::out_item_t  out_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_WAIT,
    PH_ADDR_WAIT,
    PH_WANT_WRITE,
    PH_WRITE_WAIT,
    PH_READ_WAIT
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [7:0]           seg_addr_r, seg_addr_nxt;
  logic [7:0]           bytes_left_r, bytes_left_nxt;
  logic                 out_valid_r;
  i2cms_pkg::out_item_t out_item_r, res;
  logic [7:0]           bytes_dec;
  logic                 bad;

  assign pop       = !queue_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign bytes_dec = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    seg_addr_nxt   = seg_addr_r;
    bytes_left_nxt = bytes_left_r;
    bad            = 1'b0;
    res            = '0;
    res.action     = i2cms_pkg::ACT_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (head.cmd.is_segment) begin
          seg_addr_nxt   = head.address_rw;
          bytes_left_nxt = head.byte_count;
          res.action     = i2cms_pkg::ACT_START;
          phase_nxt      = PH_START_WAIT;
        end else if (head.cmd.is_end) begin
          res.action   = i2cms_pkg::ACT_STOP;
          res.done_res = 1'b1;
        end
      end
      PH_START_WAIT: begin
        if (head.cmd.is_status) begin
          if (head.st.start_ok) begin
            res.action      = i2cms_pkg::ACT_SEND;
            res.action_byte = seg_addr_r;
            phase_nxt       = PH_ADDR_WAIT;
          end else begin
            bad = 1'b1;
          end
        end
      end
      PH_ADDR_WAIT: begin
        if (head.cmd.is_status) begin
          if (head.st.addr_ok) begin
            if (bytes_left_r == 8'd0) begin
              phase_nxt = PH_IDLE;
            end else if (!seg_addr_r[0]) begin
              phase_nxt = PH_WANT_WRITE;
            end else begin
              res.action = (bytes_left_r > 8'd1) ? i2cms_pkg::ACT_RX_ACK
                                                 : i2cms_pkg::ACT_RX_NACK;
              phase_nxt  = PH_READ_WAIT;
            end
          end else begin
            bad = 1'b1;
          end
        end
      end
      PH_WANT_WRITE: begin
        if (head.cmd.is_write) begin
          res.action      = i2cms_pkg::ACT_SEND;
          res.action_byte = head.write_byte;
          phase_nxt       = PH_WRITE_WAIT;
        end
      end
      PH_WRITE_WAIT: begin
        if (head.cmd.is_status) begin
          if (head.st.wdata_ok) begin
            bytes_left_nxt = bytes_dec;
            phase_nxt      = (bytes_dec == 8'd0) ? PH_IDLE : PH_WANT_WRITE;
          end else begin
            bad = 1'b1;
          end
        end
      end
      PH_READ_WAIT: begin
        if (head.cmd.is_status) begin
          res.rx_valid = 1'b1;
          res.rx_byte  = head.received_byte;
          if (head.st.rx_ack || (head.st.rx_nack && (bytes_left_r <= 8'd1))) begin
            bytes_left_nxt = bytes_dec;
            if (bytes_dec == 8'd0) begin
              phase_nxt = PH_IDLE;
            end else begin
              res.action = (bytes_dec > 8'd1) ? i2cms_pkg::ACT_RX_ACK
                                              : i2cms_pkg::ACT_RX_NACK;
            end
          end else begin
            bad = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (bad) begin
      res.action      = i2cms_pkg::ACT_STOP;
      res.action_byte = 8'd0;
      res.done_res    = 1'b1;
      res.failed      = 1'b1;
      res.fail_status = head.bus_status;
      phase_nxt       = PH_IDLE;
    end
    case (phase_nxt)
      PH_IDLE:       res.wants = i2cms_pkg::WANTS_SEGMENT;
      PH_WANT_WRITE: res.wants = i2cms_pkg::WANTS_WRITE;
      default:       res.wants = i2cms_pkg::WANTS_BUS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      seg_addr_r   <= 8'd0;
      bytes_left_r <= 8'd0;
      out_valid_r  <= 1'b0;
    end else if (pop) begin
      phase_r      <= phase_nxt;
      seg_addr_r   <= seg_addr_nxt;
      bytes_left_r <= bytes_left_nxt;
      out_valid_r  <= 1'b1;
      out_item_r   <= res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: rtl/i2c_master_transaction_sequencer.sv
// i2c master transaction sequencer
// in channel: in_valid / in_stall / in_data carry one item each (segment
// descriptor, write byte, bus status reply or end of list), taken at a
// rising edge with in_valid high and in_stall low
// out channel: out_valid / out_stall / out_data carry one result per item,
// naming the next bus engine action, received data and completion status
// the front decodes the command and the masked status byte and pushes the
// item into a small queue; the back runs the phase machine and loads the
// output register
// out_valid rises once an accepted item has been written into the queue and then loaded into the output register
// throughput: one item per cycle while the receiver does not stall, set by the phase machine
// when the receiver stalls, the output register holds and the queue fills;
// in_stall rises once the queue is full
// reset (rst_n low, synchronous) empties the queue and the output register
// and returns the phase to idle with segment address and count cleared
module i2c_master_transaction_sequencer #(
  parameter int QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cms_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cms_pkg::out_item_t out_data
);

  i2cms_pkg::cls_item_t cls;
  i2cms_pkg::cls_item_t head;
  logic                 push;
  logic                 pop;
  logic                 queue_full;
  logic                 queue_empty;

  i2cms_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .cls        (cls)
  );

  i2cms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  i2cms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
